// ===== sv/lpdrm_pkg.sv =====
// lpdrm_pkg: shared types and constants of the led pwm duty ramp mapper
// no dependencies; imported by lpdrm_ctrl, lpdrm_dp and the top level
package lpdrm_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT       = 2'd3;

    localparam logic [6:0] PCT_FULL   = 7'd100;
    localparam logic [6:0] PCT_HALF   = 7'd50;
    localparam logic [2:0] MAX_STEPS  = 3'd7;

    // x / 100 as (x * 5243) >> 19, exact for x below 43690
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int unsigned RECIP_SH  = 19;

    localparam logic [6:0] OFF_LVL_LONG  = 7'h7F;
    localparam logic [6:0] OFF_LVL_SHORT = 7'h3F;
    localparam logic [6:0] MAX_LVL_LONG  = 7'h7E;
    localparam logic [6:0] MAX_LVL_SHORT = 7'h3E;
    localparam logic [6:0] MIN_LVL       = 7'h01;
    localparam logic [7:0] STRIDE_LONG   = 8'd16;
    localparam logic [7:0] STRIDE_SHORT  = 8'd8;
    localparam logic [7:0] LEN_BIT_SHORT = 8'h80;

    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic clamp;
        logic target;
        logic emit_step;
        logic emit_final;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic steps_zero;
    } t_status;

endpackage

// ===== sv/led_pwm_duty_ramp_mapper_core.sv =====
// led_pwm_duty_ramp_mapper_core: top level of the led pwm duty ramp mapper
// depends on lpdrm_pkg, lpdrm_ctrl and lpdrm_dp
// a request is loaded, then passes multiply, divide, clamp, level divide and target,
// then emits n intermediate writes (0 to 7) and a final write, waiting on output stalls;
// the multi-step sequencer and shared divide-by-100 unit take no new request before it
// reset: window 0..100, long period, no inversion, stored on-level 0x01
module led_pwm_duty_ramp_mapper_core
    import lpdrm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_duty_percent,
    input  logic                  i_ramp,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_on_register_value,
    output logic                  o_last
);

    t_cmd    cmd;
    t_status status;

    lpdrm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    lpdrm_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_duty_percent      (i_duty_percent),
        .i_ramp              (i_ramp),
        .i_cmd               (cmd),
        .o_status            (status),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_on_register_value (o_on_register_value),
        .o_last              (o_last)
    );

endmodule

// ===== sv/lpdrm_ctrl.sv =====
// lpdrm_ctrl: sequencing state machine of the duty ramp mapper
// depends on lpdrm_pkg; drives the datapath lpdrm_dp by command struct
module lpdrm_ctrl
    import lpdrm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_MUL     = 7'b0000010,
        S_DIV     = 7'b0000100,
        S_CLAMP   = 7'b0001000,
        S_DIV_LVL = 7'b0010000,
        S_TARGET  = 7'b0100000,
        S_EMIT    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_DIV_LVL;
            end
            S_DIV_LVL: begin
                o_cmd.div = 1'b1;
                n_state   = S_TARGET;
            end
            S_TARGET: begin
                o_cmd.target = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    if (i_status.steps_zero) begin
                        o_cmd.emit_final = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        o_cmd.emit_step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/lpdrm_dp.sv =====
// lpdrm_dp: datapath of the duty ramp mapper, config registers and output register
// depends on lpdrm_pkg; commanded by lpdrm_ctrl
module lpdrm_dp
    import lpdrm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [7:0]            i_duty_percent,
    input  logic                  i_ramp,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_on_register_value,
    output logic                  o_last
);

    logic       r_short;
    logic [6:0] r_min_duty;
    logic [6:0] r_max_duty;
    logic       r_invert;
    logic [6:0] r_cur_lvl;

    logic [6:0]  r_duty;
    logic        r_ramp;
    logic [13:0] r_prod;
    logic [7:0]  r_q;
    logic [7:0]  r_target;
    logic [7:0]  r_walk;
    logic        r_down;
    logic [2:0]  r_steps;

    logic       r_out_valid;
    logic [7:0] r_out_val;
    logic       r_out_last;

    logic [6:0]  hi;
    logic [6:0]  lo;
    logic [6:0]  span;
    logic [6:0]  off_lvl;
    logic [6:0]  max_lvl;
    logic [7:0]  stride;
    logic [7:0]  len_bit;
    logic [26:0] recip_prod;
    logic [6:0]  scaled;
    logic [6:0]  flipped;
    logic [6:0]  clamped;
    logic [7:0]  lvl_diff;
    logic [7:0]  target;
    logic [6:0]  new_state;
    logic        down;
    logic [6:0]  lvl_gap;
    logic [6:0]  dist_sh;
    logic [2:0]  steps;
    logic [7:0]  walk_next;
    logic        out_free;

    // window and period selection
    always_comb begin
        hi      = (r_max_duty == 7'd0 || r_max_duty > PCT_FULL) ? PCT_FULL : r_max_duty;
        lo      = (r_min_duty >= PCT_FULL || r_min_duty >= hi) ? 7'd0 : r_min_duty;
        span    = hi - lo;
        off_lvl = r_short ? OFF_LVL_SHORT : OFF_LVL_LONG;
        max_lvl = r_short ? MAX_LVL_SHORT : MAX_LVL_LONG;
        stride  = r_short ? STRIDE_SHORT : STRIDE_LONG;
        len_bit = r_short ? LEN_BIT_SHORT : 8'h00;
    end

    assign recip_prod = {13'd0, r_prod} * {14'd0, RECIP_100};

    // rescale, invert and clamp to the window
    always_comb begin
        scaled  = (span != PCT_FULL) ? (lo + r_q[6:0]) : r_duty;
        flipped = PCT_FULL - scaled;
        if (r_invert) begin
            if (flipped > PCT_FULL - lo) begin
                clamped = PCT_FULL - lo;
            end else if (flipped < PCT_FULL - hi) begin
                clamped = PCT_FULL - hi;
            end else begin
                clamped = flipped;
            end
        end else begin
            if (scaled > hi) begin
                clamped = hi;
            end else if (scaled < lo) begin
                clamped = lo;
            end else begin
                clamped = scaled;
            end
        end
    end

    // on level and ramp plan
    always_comb begin
        lvl_diff = {1'b0, off_lvl} - r_q;
        if (r_duty == 7'd0) begin
            target    = {1'b0, r_invert ? max_lvl : MIN_LVL};
            new_state = r_invert ? max_lvl : MIN_LVL;
        end else if (!r_invert && r_duty >= PCT_FULL) begin
            target    = {1'b0, off_lvl};
            new_state = max_lvl;
        end else begin
            if (lvl_diff < {1'b0, MIN_LVL}) begin
                target = {1'b0, MIN_LVL};
            end else if (lvl_diff > {1'b0, max_lvl}) begin
                target = {1'b0, max_lvl};
            end else begin
                target = lvl_diff;
            end
            new_state = target[6:0];
        end
        down    = r_cur_lvl > new_state;
        lvl_gap = down ? (r_cur_lvl - new_state) : (new_state - r_cur_lvl);
        dist_sh = r_short ? (lvl_gap >> 3) : (lvl_gap >> 4);
        steps   = (dist_sh > {4'd0, MAX_STEPS}) ? MAX_STEPS : dist_sh[2:0];
        if (!r_ramp) begin
            steps = 3'd0;
        end
        walk_next = r_down ? (r_walk - stride) : (r_walk + stride);
    end

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short     <= 1'b0;
            r_min_duty  <= 7'd0;
            r_max_duty  <= PCT_FULL;
            r_invert    <= 1'b0;
            r_cur_lvl   <= MIN_LVL;
            r_steps     <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SHORT_PERIOD: r_short    <= i_cfg_data[0];
                    REG_MIN_DUTY:     r_min_duty <= i_cfg_data;
                    REG_MAX_DUTY:     r_max_duty <= i_cfg_data;
                    REG_INVERT:       r_invert   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.target) begin
                r_cur_lvl <= new_state;
                r_steps   <= steps;
            end else if (i_cmd.emit_step) begin
                r_steps <= r_steps - 3'd1;
            end
            if (i_cmd.emit_step || i_cmd.emit_final) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_duty <= (i_duty_percent > {1'b0, PCT_FULL}) ? PCT_FULL : i_duty_percent[6:0];
            r_ramp <= i_ramp;
        end
        if (i_cmd.mul) begin
            r_prod <= ({7'd0, r_duty} * {7'd0, span}) + {7'd0, PCT_HALF};
        end
        if (i_cmd.div) begin
            r_q <= recip_prod[RECIP_SH+7:RECIP_SH];
        end
        if (i_cmd.clamp) begin
            r_duty <= clamped;
            r_prod <= r_short ? {1'b0, clamped, 6'd0} : {clamped, 7'd0};
        end
        if (i_cmd.target) begin
            r_target <= target;
            r_walk   <= {1'b0, r_cur_lvl};
            r_down   <= down;
        end
        if (i_cmd.emit_step) begin
            r_walk     <= walk_next;
            r_out_val  <= walk_next | len_bit;
            r_out_last <= 1'b0;
        end
        if (i_cmd.emit_final) begin
            r_out_val  <= r_target | len_bit;
            r_out_last <= 1'b1;
        end
    end

    assign o_status.out_free   = out_free;
    assign o_status.steps_zero = (r_steps == 3'd0);

    assign o_valid             = r_out_valid;
    assign o_on_register_value = r_out_val;
    assign o_last              = r_out_last;

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for led_pwm_duty_ramp_mapper_core
// holds a duty-to-level predictor in a small scoreboard class, random and directed requests
// depends on lpdrm_pkg and led_pwm_duty_ramp_mapper_core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lpdrm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } t_level_write;

    class level_scoreboard;
        logic                  short_mode;
        logic [6:0]            min_duty;
        logic [6:0]            max_duty;
        logic                  invert;
        logic [6:0]            stored_level;
        t_level_write          expected_writes[$];
        int unsigned           errors;
        int unsigned           requests;
        int unsigned           writes_seen;
        int unsigned           steps_seen;

        function new();
            short_mode   = 1'b0;
            min_duty     = 7'd0;
            max_duty     = 7'd100;
            invert       = 1'b0;
            stored_level = MIN_LVL;
            errors       = 0;
            requests     = 0;
            writes_seen  = 0;
            steps_seen   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SHORT_PERIOD: short_mode = data[0];
                REG_MIN_DUTY:     min_duty   = data;
                REG_MAX_DUTY:     max_duty   = data;
                REG_INVERT:       invert     = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_writes.size();
        endfunction

        // works out the on-level writes caused by one accepted request
        function void note_request(logic [7:0] duty_in, logic ramp_in);
            int unsigned  period, off_lvl, max_lvl, shift, stride, len_bit;
            int unsigned  hi, lo, span, duty, part, target, new_level, prev, steps;
            logic         down;
            t_level_write w;

            period  = short_mode ? 64 : 128;
            off_lvl = short_mode ? OFF_LVL_SHORT : OFF_LVL_LONG;
            max_lvl = short_mode ? MAX_LVL_SHORT : MAX_LVL_LONG;
            shift   = short_mode ? 3 : 4;
            stride  = 1 << shift;
            len_bit = short_mode ? LEN_BIT_SHORT : 8'h00;

            hi   = (max_duty == 0 || max_duty > 100) ? 100 : max_duty;
            lo   = (min_duty >= 100 || min_duty >= hi) ? 0 : min_duty;
            span = hi - lo;

            duty = (duty_in > 100) ? 100 : duty_in;
            if (span != 100)
                duty = lo + (duty * span + 50) / 100;

            if (invert) begin
                duty = 100 - duty;
                if (duty > 100 - lo)
                    duty = 100 - lo;
                else if (duty < 100 - hi)
                    duty = 100 - hi;
            end else begin
                if (duty > hi)
                    duty = hi;
                else if (duty < lo)
                    duty = lo;
            end

            if (duty == 0) begin
                target    = invert ? max_lvl : MIN_LVL;
                new_level = target;
            end else if (!invert && duty >= 100) begin
                target    = off_lvl;
                new_level = max_lvl;
            end else begin
                part   = ((period * duty) / 100) & 8'hFF;
                target = (off_lvl - part) & 8'hFF;
                if (target < MIN_LVL)
                    target = MIN_LVL;
                else if (target > max_lvl)
                    target = max_lvl;
                new_level = target;
            end

            prev         = stored_level;
            stored_level = new_level[6:0];

            if (ramp_in) begin
                down  = prev > new_level;
                steps = (down ? (prev - new_level) : (new_level - prev)) >> shift;
                if (steps > MAX_STEPS)
                    steps = MAX_STEPS;
                for (int unsigned k = 0; k < steps; k++) begin
                    prev    = down ? ((prev - stride) & 8'hFF) : ((prev + stride) & 8'hFF);
                    w.value = 8'(prev | len_bit);
                    w.last  = 1'b0;
                    expected_writes.push_back(w);
                end
            end
            w.value = 8'(target | len_bit);
            w.last  = 1'b1;
            expected_writes.push_back(w);
            requests++;
        endfunction

        function void check_write(logic [7:0] value, logic last);
            t_level_write w;
            writes_seen++;
            if (!last)
                steps_seen++;
            if (expected_writes.size() == 0) begin
                $display("%0t: unexpected write: got value %02h last %0b", $time, value, last);
                errors++;
                return;
            end
            w = expected_writes.pop_front();
            if (value !== w.value || last !== w.last) begin
                $display("%0t: write mismatch: expected value %02h last %0b, got value %02h last %0b",
                         $time, w.value, w.last, value, last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [7:0]            i_duty_percent;
    logic                  i_ramp;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [7:0]            o_on_register_value;
    logic                  o_last;

    level_scoreboard sb;
    int unsigned     send_idle_pct;
    int unsigned     recv_stall_pct = 0;
    int unsigned     settings_used;
    int unsigned     cycle_count;

    led_pwm_duty_ramp_mapper_core i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_duty_percent      (i_duty_percent),
        .i_ramp              (i_ramp),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_on_register_value (o_on_register_value),
        .o_last              (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_write(o_on_register_value, o_last);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d writes still expected", $time, sb.pending());
        $display("FAIL led_pwm_duty_ramp_mapper_core");
        $finish;
    end

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic configure(input logic mode, input logic [6:0] lo, input logic [6:0] hi,
                             input logic inv);
        set_reg(REG_SHORT_PERIOD, {6'd0, mode});
        set_reg(REG_MIN_DUTY, lo);
        set_reg(REG_MAX_DUTY, hi);
        set_reg(REG_INVERT, {6'd0, inv});
        settings_used++;
    endtask

    // entered and left at a falling edge
    task automatic send_request(input logic [7:0] duty, input logic ramp);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            do
                @(negedge i_clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        i_valid        = 1'b1;
        i_duty_percent = duty;
        i_ramp         = ramp;
        do
            @(posedge i_clk);
        while (o_stall);
        sb.note_request(duty, ramp);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_phase(input int unsigned count, input int unsigned idle_sel);
        logic [7:0] duty;
        case (idle_sel % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
        endcase
        repeat (count) begin
            case ($urandom_range(9))
                0:       duty = 8'd0;
                1:       duty = 8'd100;
                2, 3:    duty = 8'($urandom_range(255, 101));
                default: duty = 8'($urandom_range(100));
            endcase
            send_request(duty, $urandom_range(99) < 70);
        end
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        sb             = new();
        settings_used  = 0;
        send_idle_pct  = 0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_SHORT_PERIOD;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_duty_percent = 8'd0;
        i_ramp         = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: reset window, full ramps both ways, saturation
        send_request(8'd0, 1'b0);
        send_request(8'd100, 1'b1);
        send_request(8'd255, 1'b1);
        send_request(8'd101, 1'b0);
        send_request(8'd0, 1'b1);
        send_request(8'd50, 1'b1);
        send_request(8'd1, 1'b1);
        send_request(8'd99, 1'b1);
        send_request(8'd128, 1'b0);
        wait_idle();

        // inverted: level wrap and zero duty to max level
        configure(1'b0, 7'd0, 7'd100, 1'b1);
        send_request(8'd0, 1'b1);
        send_request(8'd100, 1'b1);
        wait_idle();

        // short period after a long-period level: step count saturates
        configure(1'b1, 7'd0, 7'd100, 1'b0);
        send_request(8'd100, 1'b1);
        send_request(8'd0, 1'b1);
        send_request(8'd64, 1'b1);
        send_request(8'd255, 1'b1);
        wait_idle();

        configure(1'b1, 7'd30, 7'd70, 1'b1);
        send_request(8'd0, 1'b1);
        send_request(8'd100, 1'b1);
        send_request(8'd37, 1'b0);
        send_request(8'd255, 1'b1);
        wait_idle();

        configure(1'b0, 7'd0, 7'd100, 1'b0);
        random_phase(25, 0);
        configure(1'b1, 7'd0, 7'd100, 1'b0);
        random_phase(25, 1);
        configure(1'b0, 7'd20, 7'd80, 1'b0);
        random_phase(25, 2);
        configure(1'b1, 7'd20, 7'd80, 1'b1);
        random_phase(25, 3);
        configure(1'b0, 7'd0, 7'd100, 1'b1);
        random_phase(25, 0);
        configure(1'b1, 7'd99, 7'd100, 1'b0);
        random_phase(25, 1);
        configure(1'b0, 7'd127, 7'd127, 1'b0);
        random_phase(25, 2);
        configure(1'b1, 7'd50, 7'd0, 1'b1);
        random_phase(25, 3);
        configure(1'b0, 7'd60, 7'd40, 1'b1);
        random_phase(25, 0);
        for (int unsigned p = 0; p < 3; p++) begin
            configure(1'($urandom_range(1)), 7'($urandom_range(127)), 7'($urandom_range(127)),
                      1'($urandom_range(1)));
            random_phase(25, p + 1);
        end

        wait_idle();
        $display("requests: %0d over %0d register settings; writes checked: %0d (%0d ramp steps)",
                 sb.requests, settings_used, sb.writes_seen, sb.steps_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS led_pwm_duty_ramp_mapper_core");
        end else begin
            $display("FAIL led_pwm_duty_ramp_mapper_core");
        end
        $finish;
    end

endmodule
